// ===== design/jasd_pkg.sv =====
// Shared types, constants and the microprogram for the joystick axis smoother.
// Used by jasd_seq, jasd_datapath and joystick_axis_smoother_deadzone.
`timescale 1ns / 1ps

package jasd_pkg;

  // Sample and level widths
  localparam int SAMPLE_BITS = 10;
  localparam int RAW_W       = SAMPLE_BITS + 1;
  localparam int X_W         = 17;
  localparam int X_SHIFT     = 16 - SAMPLE_BITS;
  localparam int LEVEL_W     = 18;
  localparam int AXIS_W      = 17;
  localparam int WEIGHT_W    = 16;
  localparam int DZ_W        = 16;
  localparam int GAIN_W      = 24;
  localparam int MUL_A_W     = GAIN_W + 1;
  localparam int MUL_B_W     = LEVEL_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = 36;
  localparam int SHIFTED_W   = ACC_W - 16;

  // Stream and configuration widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RAW_W + AXIS_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESCALE_GAIN  = 2'd2;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd52429;
  localparam logic [DZ_W-1:0]     DZ_RST     = 16'd3277;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd68986;

  localparam logic [15:0] AXIS_MAX = 16'hFFFF;

  // Microprogram
  localparam int PC_W = 3;

  typedef enum logic [1:0] {
    COND_SEQ,
    COND_WAIT_IN,
    COND_BELOW_DZ,
    COND_WAIT_OUT
  } jasd_cond_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_W_S,
    MUL_IW_X,
    MUL_D_G
  } jasd_mul_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } jasd_acc_t;

  typedef struct packed {
    jasd_cond_t         cond;
    logic [PC_W-1:0]    target;
    jasd_mul_t          mul_sel;
    jasd_acc_t          acc_op;
    logic               s_wr;
    logic               diff_wr;
    logic               out_wr;
  } jasd_ctrl_t;

  typedef struct packed {
    logic below_dz;
    logic out_slot;
  } jasd_status_t;

  // One control word per step
  function automatic jasd_ctrl_t jasd_ucode(input logic [PC_W-1:0] pc);
    jasd_ctrl_t cw;
    cw = '{cond: COND_SEQ, target: '0, mul_sel: MUL_NONE, acc_op: ACC_HOLD,
           s_wr: 1'b0, diff_wr: 1'b0, out_wr: 1'b0};
    case (pc)
      3'd0: begin
        cw.cond   = COND_WAIT_IN;
        cw.target = 3'd1;
      end
      3'd1: cw.mul_sel = MUL_W_S;
      3'd2: begin
        cw.mul_sel = MUL_IW_X;
        cw.acc_op  = ACC_LOAD;
      end
      3'd3: cw.acc_op = ACC_ADD;
      3'd4: cw.s_wr = 1'b1;
      3'd5: begin
        cw.diff_wr = 1'b1;
        cw.cond    = COND_BELOW_DZ;
        cw.target  = 3'd7;
      end
      3'd6: cw.mul_sel = MUL_D_G;
      3'd7: begin
        cw.out_wr = 1'b1;
        cw.cond   = COND_WAIT_OUT;
        cw.target = 3'd0;
      end
      default: cw.cond = COND_SEQ;
    endcase
    return cw;
  endfunction

endpackage

// ===== design/jasd_seq.sv =====
// Step counter and microprogram table for the axis smoother.
// Depends on jasd_pkg for the control word, conditions and program.
`timescale 1ns / 1ps

module jasd_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  jasd_pkg::jasd_status_t status,
  output jasd_pkg::jasd_ctrl_t   ctrl
);

  logic [jasd_pkg::PC_W-1:0] pc_r;
  logic [jasd_pkg::PC_W-1:0] pc_nxt;

  // Fetch the control word for this step
  always_comb begin
    ctrl = jasd_pkg::jasd_ucode(pc_r);
  end

  // Pick the next step
  always_comb begin
    pc_nxt = pc_r + 1'b1;
    case (ctrl.cond)
      jasd_pkg::COND_SEQ:      pc_nxt = pc_r + 1'b1;
      jasd_pkg::COND_WAIT_IN:  pc_nxt = in_tvalid ? ctrl.target : pc_r;
      jasd_pkg::COND_BELOW_DZ: pc_nxt = status.below_dz ? ctrl.target : pc_r + 1'b1;
      jasd_pkg::COND_WAIT_OUT: pc_nxt = status.out_slot ? ctrl.target : pc_r;
      default:                 pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== design/jasd_datapath.sv =====
// Datapath for the axis smoother: config registers, shared multiplier,
// accumulator, smoothed level, dead zone and output register.
// Depends on jasd_pkg; driven by control words from jasd_seq.
`timescale 1ns / 1ps

module jasd_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  jasd_pkg::jasd_ctrl_t                 ctrl,
  output jasd_pkg::jasd_status_t               status,
  input  logic                                 in_fire,
  input  logic [jasd_pkg::SAMPLE_BITS-1:0]     pos_sample,
  input  logic [jasd_pkg::SAMPLE_BITS-1:0]     neg_sample,
  input  logic                                 clear,
  input  logic                                 cfg_fire,
  input  logic [jasd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jasd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 out_tready,
  output logic                                 out_valid,
  output logic signed [jasd_pkg::RAW_W-1:0]    out_raw,
  output logic signed [jasd_pkg::AXIS_W-1:0]   out_axis
);

  // Configuration
  logic [jasd_pkg::WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [jasd_pkg::DZ_W-1:0]     dz_r, dz_nxt;
  logic [jasd_pkg::GAIN_W-1:0]   gain_r, gain_nxt;

  // Working registers
  logic signed [jasd_pkg::RAW_W-1:0]   raw_r, raw_nxt;
  logic signed [jasd_pkg::LEVEL_W-1:0] s_r, s_nxt;
  logic signed [jasd_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [jasd_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [jasd_pkg::LEVEL_W-1:0]        diff_r, diff_nxt;
  logic                                zero_r, zero_nxt;

  // Output register
  logic                                out_valid_r, out_valid_nxt;
  logic signed [jasd_pkg::RAW_W-1:0]   out_raw_r, out_raw_nxt;
  logic signed [jasd_pkg::AXIS_W-1:0]  out_axis_r, out_axis_nxt;

  // Combinational helpers
  logic signed [jasd_pkg::X_W-1:0]       x_val;
  logic [jasd_pkg::WEIGHT_W:0]           inv_weight;
  logic signed [jasd_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [jasd_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [jasd_pkg::SHIFTED_W-1:0] shifted;
  logic signed [jasd_pkg::LEVEL_W-1:0]   s_sat;
  logic signed [jasd_pkg::LEVEL_W:0]     s_ext;
  logic [jasd_pkg::LEVEL_W:0]            mag_ext;
  logic [jasd_pkg::LEVEL_W-1:0]          mag;
  logic [jasd_pkg::LEVEL_W-1:0]          dz_ext;
  logic [15:0]                           val;
  logic                                  out_load;

  // Scale the difference up to Q16 full scale
  assign x_val      = {raw_r, {jasd_pkg::X_SHIFT{1'b0}}};
  assign inv_weight = 17'h10000 - {1'b0, weight_r};

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      jasd_pkg::MUL_W_S: begin
        mul_a = $signed({{(jasd_pkg::MUL_A_W - jasd_pkg::WEIGHT_W){1'b0}}, weight_r});
        mul_b = $signed({s_r[jasd_pkg::LEVEL_W-1], s_r});
      end
      jasd_pkg::MUL_IW_X: begin
        mul_a = $signed({{(jasd_pkg::MUL_A_W - jasd_pkg::WEIGHT_W - 1){1'b0}}, inv_weight});
        mul_b = $signed({{(jasd_pkg::MUL_B_W - jasd_pkg::X_W){x_val[jasd_pkg::X_W-1]}},
                         x_val});
      end
      jasd_pkg::MUL_D_G: begin
        mul_a = $signed({1'b0, gain_r});
        mul_b = $signed({1'b0, diff_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Floor shift and clamp of the new smoothed level
  assign shifted = acc_r[jasd_pkg::ACC_W-1:16];
  always_comb begin
    if (shifted > $signed(20'sd131071)) begin
      s_sat = 18'sh1FFFF;
    end else if (shifted < -$signed(20'sd131072)) begin
      s_sat = 18'sh20000;
    end else begin
      s_sat = shifted[jasd_pkg::LEVEL_W-1:0];
    end
  end

  // Magnitude against dead zone
  assign s_ext   = {s_r[jasd_pkg::LEVEL_W-1], s_r};
  assign mag_ext = s_r[jasd_pkg::LEVEL_W-1] ? $unsigned(-s_ext) : $unsigned(s_ext);
  assign mag     = mag_ext[jasd_pkg::LEVEL_W-1:0];
  assign dz_ext  = {{(jasd_pkg::LEVEL_W - jasd_pkg::DZ_W){1'b0}}, dz_r};
  assign status.below_dz = (mag < dz_ext);

  // Rescaled magnitude, saturated
  always_comb begin
    if (zero_r) begin
      val = '0;
    end else if (|prod_r[jasd_pkg::PROD_W-1:32]) begin
      val = jasd_pkg::AXIS_MAX;
    end else begin
      val = prod_r[31:16];
    end
  end

  assign status.out_slot = !out_valid_r || out_tready;
  assign out_load        = ctrl.out_wr && status.out_slot;

  // Next values
  always_comb begin
    weight_nxt = weight_r;
    dz_nxt     = dz_r;
    gain_nxt   = gain_r;
    if (cfg_fire) begin
      case (cfg_index)
        jasd_pkg::CFG_FILTER_WEIGHT: weight_nxt = cfg_data[jasd_pkg::WEIGHT_W-1:0];
        jasd_pkg::CFG_DEAD_ZONE:     dz_nxt     = cfg_data[jasd_pkg::DZ_W-1:0];
        jasd_pkg::CFG_RESCALE_GAIN:  gain_nxt   = cfg_data[jasd_pkg::GAIN_W-1:0];
        default:                     weight_nxt = weight_r;
      endcase
    end

    raw_nxt = raw_r;
    s_nxt   = s_r;
    if (in_fire) begin
      raw_nxt = $signed({1'b0, pos_sample}) - $signed({1'b0, neg_sample});
      if (clear) begin
        s_nxt = '0;
      end
    end else if (ctrl.s_wr) begin
      s_nxt = s_sat;
    end

    prod_nxt = (ctrl.mul_sel != jasd_pkg::MUL_NONE) ? mul_a * mul_b : prod_r;

    case (ctrl.acc_op)
      jasd_pkg::ACC_LOAD: acc_nxt = prod_r[jasd_pkg::ACC_W-1:0];
      jasd_pkg::ACC_ADD:  acc_nxt = acc_r + prod_r[jasd_pkg::ACC_W-1:0];
      default:            acc_nxt = acc_r;
    endcase

    diff_nxt = ctrl.diff_wr ? (mag - dz_ext) : diff_r;
    zero_nxt = ctrl.diff_wr ? status.below_dz : zero_r;

    out_raw_nxt  = out_raw_r;
    out_axis_nxt = out_axis_r;
    if (out_load) begin
      out_raw_nxt  = raw_r;
      out_axis_nxt = s_r[jasd_pkg::LEVEL_W-1] ? -$signed({1'b0, val})
                                             : $signed({1'b0, val});
    end
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Control and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= jasd_pkg::WEIGHT_RST;
      dz_r        <= jasd_pkg::DZ_RST;
      gain_r      <= jasd_pkg::GAIN_RST;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      weight_r    <= weight_nxt;
      dz_r        <= dz_nxt;
      gain_r      <= gain_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    diff_r     <= diff_nxt;
    zero_r     <= zero_nxt;
    out_raw_r  <= out_raw_nxt;
    out_axis_r <= out_axis_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_raw   = out_raw_r;
  assign out_axis  = out_axis_r;

endmodule

// ===== design/joystick_axis_smoother_deadzone.sv =====
// Top level of the joystick axis smoother with dead zone and rescale.
// Instantiates jasd_seq and jasd_datapath; uses jasd_pkg.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata: pos_sample, neg_sample; tuser: clear
//   out_    | out | out_tvalid/tready  | tdata: raw_difference, axis_value
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// An item passes through the microprogram from acceptance to the output register,
// skipping the rescale step inside the dead zone; it runs one step per cycle while
// not waiting on input or output, and its single shared multiplier forms three
// products per item (two inside). The next item is accepted the cycle after the
// result is loaded, and a stalled output holds the last step.
// Configuration writes are taken every cycle (cfg_ready is 1).
// Reset clears the smoothed level and loads the register defaults.
`timescale 1ns / 1ps

module joystick_axis_smoother_deadzone (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [9:0] pos_sample, [19:10] neg_sample, [23:20] zero
  input  logic [jasd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] clear
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [10:0] raw_difference, [27:11] axis_value, [31:28] zero
  output logic [jasd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jasd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jasd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  jasd_pkg::jasd_ctrl_t   ctrl;
  jasd_pkg::jasd_status_t status;
  logic                   in_fire;
  logic signed [jasd_pkg::RAW_W-1:0]  out_raw;
  logic signed [jasd_pkg::AXIS_W-1:0] out_axis;

  // Accept input only while the program waits for it
  assign in_tready = (ctrl.cond == jasd_pkg::COND_WAIT_IN);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  jasd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .ctrl      (ctrl)
  );

  jasd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .status     (status),
    .in_fire    (in_fire),
    .pos_sample (in_tdata[jasd_pkg::SAMPLE_BITS-1:0]),
    .neg_sample (in_tdata[2*jasd_pkg::SAMPLE_BITS-1:jasd_pkg::SAMPLE_BITS]),
    .clear      (in_tuser),
    .cfg_fire   (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_raw    (out_raw),
    .out_axis   (out_axis)
  );

  // Pack the result word
  assign out_tdata = {{(jasd_pkg::OUT_TDATA_W - jasd_pkg::RAW_W - jasd_pkg::AXIS_W){1'b0}},
                      out_axis, out_raw};

endmodule
